// File: src/lcsm_pkg.sv
// shared types and constants for the li chao segment max tree
`default_nettype none
package lcsm_pkg;

  localparam int unsigned ID_W   = 16;
  localparam int unsigned X_W    = 16;
  localparam int unsigned YIN_W  = 30;
  localparam int unsigned Y_W    = 31;
  localparam int unsigned NUM_W  = Y_W + X_W;
  localparam int unsigned PROD_W = NUM_W + X_W;

  localparam logic ACT_QUERY  = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  localparam logic [2:0] CMP_LAST = 3'd7;

  typedef struct packed {
    logic             action;
    logic [X_W-1:0]   query_x;
    logic [X_W-1:0]   x_a;
    logic [YIN_W-1:0] y_a;
    logic [X_W-1:0]   x_b;
    logic [YIN_W-1:0] y_b;
  } lcsm_in_t;

  typedef struct packed {
    logic [ID_W-1:0] segment_id;
    logic            store_full;
  } lcsm_out_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [X_W-1:0]  lo;
    logic [X_W-1:0]  hi;
    logic [Y_W-1:0]  yl;
    logic [Y_W-1:0]  yr;
  } seg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_Q_RD,
    ST_Q_CHK,
    ST_Q_SEG,
    ST_Q_GO,
    ST_Q_WAIT,
    ST_Q_NEXT,
    ST_I_VISIT,
    ST_I_POP,
    ST_P_RD,
    ST_P_CHK,
    ST_P_SEG,
    ST_P_GO1,
    ST_P_W1,
    ST_P_GO2,
    ST_P_W2,
    ST_P_GO3,
    ST_P_W3,
    ST_DONE
  } st_e;

endpackage
`default_nettype wire

// File: src/li_chao_segment_max_tree_core.sv
// li chao segment tree top: sequencer, stack, compare unit and the two memories
// query: one root-to-leaf walk over ~17 tree levels, with a compare per covering segment
// insert: tree descent of the span plus, per placed node, node and segment reads and up to 3 compares
// each compare runs one 47x16 multiplier over eight steps; one request is in work at a time
// reset: node memory zero sweep over all 2^(clog2(X_MAX)+1) entries (131072), requests stalled
// a finished result waits in an output register while the next request is accepted
`default_nettype none
module li_chao_segment_max_tree_core import lcsm_pkg::*; #(
  parameter int unsigned X_MAX        = 65535,
  parameter int unsigned MAX_SEGMENTS = 65535,
  parameter int unsigned Y_BITS       = 30
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire lcsm_in_t  in_req_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output lcsm_out_t      out_rsp_o
);

  localparam int unsigned NODE_AW = $clog2(X_MAX) + 1;
  localparam int unsigned SEG_AW  = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned SEG_DW  = 2 * X_W + 2 * Y_BITS;
  localparam int unsigned STK_D   = NODE_AW;
  localparam int unsigned SP_W    = $clog2(STK_D + 1);
  localparam int unsigned SP_IW   = $clog2(STK_D);

  localparam logic [X_W-1:0]  XMAX_L   = X_W'(X_MAX);
  localparam logic [ID_W-1:0] MAXSEG_L = ID_W'(MAX_SEGMENTS);
  localparam logic [Y_W-1:0]  YMASK    = Y_W'((64'd1 << Y_BITS) - 64'd1);

  st_e state_q, state_d;

  // request registers
  logic             is_query_q;
  logic [X_W-1:0]   cmp_x_q;
  seg_t             a_q, b_q, new_q;
  logic [X_W-1:0]   left_q, right_q;
  logic [ID_W-1:0]  count_q;
  logic [ID_W-1:0]  rd_id_q;
  lcsm_out_t        res_q, out_q;
  logic             out_valid_q;

  // tree walk position and pending right subtrees
  logic [NODE_AW-1:0] node_q;
  logic [X_W-1:0]     lo_q, hi_q;
  logic [NODE_AW-1:0] stk_node_q [STK_D];
  logic [X_W-1:0]     stk_lo_q   [STK_D];
  logic [X_W-1:0]     stk_hi_q   [STK_D];
  logic [SP_W-1:0]    sp_q, sp_m1;

  logic [X_W-1:0] mid;
  logic           leaf, outside, covered;
  logic           accept, insert_ok, store_full;

  // decoded insert
  logic [Y_W-1:0]  ya, yb, yl, yr;
  logic [X_W-1:0]  l, r, left, right;
  logic [ID_W-1:0] new_id;

  // memory and compare handshakes
  logic                node_rd_en, node_wr_en, node_busy;
  logic [ID_W-1:0]     node_rd;
  logic                seg_rd_en, seg_wr_en;
  logic [SEG_DW-1:0]   seg_wr, seg_rd;
  seg_t                seg_rec;
  logic                cmp_start, cmp_done, cmp_win;
  seg_t                cmp_a, cmp_b;
  logic                out_free;

  assign mid     = X_W'((17'(lo_q) + 17'(hi_q)) >> 1);
  assign leaf    = lo_q >= hi_q;
  assign outside = (hi_q < left_q) || (lo_q > right_q);
  assign covered = (left_q <= lo_q) && (hi_q <= right_q);
  assign sp_m1   = sp_q - 1'b1;

  assign in_stall_o = (state_q != ST_IDLE) || node_busy;
  assign accept     = in_valid_i && !in_stall_o;
  assign store_full = count_q >= MAXSEG_L;
  assign insert_ok  = accept && (in_req_i.action == ACT_INSERT) && !store_full;
  assign out_free   = !out_valid_q || !out_stall_i;

  // endpoint ordering; a vertical segment collapses to its higher point
  assign ya = {1'b0, in_req_i.y_a} & YMASK;
  assign yb = {1'b0, in_req_i.y_b} & YMASK;
  always_comb begin
    if (in_req_i.x_a == in_req_i.x_b) begin
      l  = in_req_i.x_a;
      r  = in_req_i.x_a;
      yl = (ya > yb) ? ya : yb;
      yr = (ya > yb) ? ya : yb;
    end else if (in_req_i.x_a < in_req_i.x_b) begin
      l  = in_req_i.x_a;
      r  = in_req_i.x_b;
      yl = ya;
      yr = yb;
    end else begin
      l  = in_req_i.x_b;
      r  = in_req_i.x_a;
      yl = yb;
      yr = ya;
    end
  end
  assign left   = (l < X_W'(1)) ? X_W'(1) : l;
  assign right  = (r > XMAX_L) ? XMAX_L : r;
  assign new_id = count_q + 1'b1;
  assign seg_wr = {l, r, yl[Y_BITS-1:0], yr[Y_BITS-1:0]};

  always_comb begin
    seg_rec    = '0;
    seg_rec.id = rd_id_q;
    seg_rec.lo = seg_rd[SEG_DW-1 -: X_W];
    seg_rec.hi = seg_rd[SEG_DW-X_W-1 -: X_W];
    seg_rec.yl = Y_W'(seg_rd[2*Y_BITS-1 -: Y_BITS]);
    seg_rec.yr = Y_W'(seg_rd[Y_BITS-1:0]);
  end

  // query compares candidate (b) against best so far (a); placing compares new (a) to held (b)
  assign cmp_a = is_query_q ? b_q : a_q;
  assign cmp_b = is_query_q ? a_q : b_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_req_i.action == ACT_QUERY) begin
            if ((in_req_i.query_x == '0) || (in_req_i.query_x > XMAX_L)) state_d = ST_DONE;
            else state_d = ST_Q_RD;
          end else if (store_full || (left > right)) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_I_VISIT;
          end
        end
      end
      ST_Q_RD:    state_d = ST_Q_CHK;
      ST_Q_CHK:   state_d = (node_rd != '0) ? ST_Q_SEG : ST_Q_NEXT;
      ST_Q_SEG:   state_d = (a_q.id == '0) ? ST_Q_NEXT : ST_Q_GO;
      ST_Q_GO:    state_d = ST_Q_WAIT;
      ST_Q_WAIT:  if (cmp_done) state_d = ST_Q_NEXT;
      ST_Q_NEXT:  state_d = leaf ? ST_DONE : ST_Q_RD;
      ST_I_VISIT: begin
        if (outside) state_d = ST_I_POP;
        else if (covered) state_d = ST_P_RD;
      end
      ST_I_POP:   state_d = (sp_q == '0) ? ST_DONE : ST_I_VISIT;
      ST_P_RD:    state_d = ST_P_CHK;
      ST_P_CHK:   state_d = (node_rd == '0) ? ST_I_POP : ST_P_SEG;
      ST_P_SEG:   state_d = ST_P_GO1;
      ST_P_GO1:   state_d = ST_P_W1;
      ST_P_W1:    if (cmp_done) state_d = leaf ? ST_I_POP : ST_P_GO2;
      ST_P_GO2:   state_d = ST_P_W2;
      ST_P_W2:    if (cmp_done) state_d = cmp_win ? ST_P_RD : ST_P_GO3;
      ST_P_GO3:   state_d = ST_P_W3;
      ST_P_W3:    if (cmp_done) state_d = cmp_win ? ST_P_RD : ST_I_POP;
      ST_DONE:    if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // memory and compare strobes
  always_comb begin
    node_rd_en = (state_q == ST_Q_RD) || (state_q == ST_P_RD);
    node_wr_en = ((state_q == ST_P_CHK) && (node_rd == '0)) ||
                 ((state_q == ST_P_W1) && cmp_done && cmp_win);
    seg_rd_en  = ((state_q == ST_Q_CHK) || (state_q == ST_P_CHK)) && (node_rd != '0);
    seg_wr_en  = insert_ok;
    cmp_start  = (state_q == ST_Q_GO) || (state_q == ST_P_GO1) ||
                 (state_q == ST_P_GO2) || (state_q == ST_P_GO3);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (insert_ok) count_q <= new_id;
      if (accept) sp_q <= '0;
      else if ((state_q == ST_I_VISIT) && !outside && !covered) sp_q <= sp_q + 1'b1;
      else if ((state_q == ST_I_POP) && (sp_q != '0)) sp_q <= sp_m1;
      if ((state_q == ST_DONE) && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          is_query_q       <= (in_req_i.action == ACT_QUERY);
          cmp_x_q          <= in_req_i.query_x;
          a_q              <= '0;
          node_q           <= NODE_AW'(1);
          lo_q             <= X_W'(1);
          hi_q             <= XMAX_L;
          res_q.segment_id <= '0;
          res_q.store_full <= 1'b0;
          if (in_req_i.action == ACT_INSERT) begin
            if (store_full) begin
              res_q.store_full <= 1'b1;
            end else begin
              new_q            <= '{id: new_id, lo: l, hi: r, yl: yl, yr: yr};
              left_q           <= left;
              right_q          <= right;
              res_q.segment_id <= new_id;
            end
          end
        end
      end
      ST_Q_CHK, ST_P_CHK: rd_id_q <= node_rd;
      ST_Q_SEG: begin
        b_q <= seg_rec;
        if (a_q.id == '0) a_q <= seg_rec;
      end
      ST_Q_WAIT: if (cmp_done && cmp_win) a_q <= b_q;
      ST_Q_NEXT: begin
        if (leaf) begin
          res_q.segment_id <= a_q.id;
        end else if (cmp_x_q <= mid) begin
          node_q <= {node_q[NODE_AW-2:0], 1'b0};
          hi_q   <= mid;
        end else begin
          node_q <= {node_q[NODE_AW-2:0], 1'b1};
          lo_q   <= mid + 1'b1;
        end
      end
      ST_I_VISIT: begin
        if (!outside && covered) begin
          a_q <= new_q;
        end else if (!outside) begin
          stk_node_q[sp_q[SP_IW-1:0]] <= {node_q[NODE_AW-2:0], 1'b1};
          stk_lo_q[sp_q[SP_IW-1:0]]   <= mid + 1'b1;
          stk_hi_q[sp_q[SP_IW-1:0]]   <= hi_q;
          node_q                      <= {node_q[NODE_AW-2:0], 1'b0};
          hi_q                        <= mid;
        end
      end
      ST_I_POP: begin
        if (sp_q != '0) begin
          node_q <= stk_node_q[sp_m1[SP_IW-1:0]];
          lo_q   <= stk_lo_q[sp_m1[SP_IW-1:0]];
          hi_q   <= stk_hi_q[sp_m1[SP_IW-1:0]];
        end
      end
      ST_P_SEG: begin
        b_q     <= seg_rec;
        cmp_x_q <= mid;
      end
      ST_P_W1: begin
        if (cmp_done) begin
          // winner stays in the node, loser carries on downward
          if (cmp_win) begin
            a_q <= b_q;
            b_q <= a_q;
          end
          cmp_x_q <= lo_q;
        end
      end
      ST_P_W2: begin
        if (cmp_done) begin
          if (cmp_win) begin
            node_q <= {node_q[NODE_AW-2:0], 1'b0};
            hi_q   <= mid;
          end else begin
            cmp_x_q <= hi_q;
          end
        end
      end
      ST_P_W3: begin
        if (cmp_done && cmp_win) begin
          node_q <= {node_q[NODE_AW-2:0], 1'b1};
          lo_q   <= mid + 1'b1;
        end
      end
      ST_DONE: if (out_free) out_q <= res_q;
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  lcsm_node_store #(
    .AW(NODE_AW)
  ) u_node_store (
    .clk_i,
    .rst_ni,
    .rd_en_i   (node_rd_en),
    .rd_addr_i (node_q),
    .wr_en_i   (node_wr_en),
    .wr_addr_i (node_q),
    .wr_data_i (a_q.id),
    .rd_data_o (node_rd),
    .busy_o    (node_busy)
  );

  lcsm_seg_store #(
    .AW(SEG_AW),
    .DW(SEG_DW)
  ) u_seg_store (
    .clk_i,
    .wr_en_i   (seg_wr_en),
    .wr_addr_i (new_id[SEG_AW-1:0]),
    .wr_data_i (seg_wr),
    .rd_en_i   (seg_rd_en),
    .rd_addr_i (node_rd[SEG_AW-1:0]),
    .rd_data_o (seg_rd)
  );

  lcsm_cmp u_cmp (
    .clk_i,
    .rst_ni,
    .start_i (cmp_start),
    .a_i     (cmp_a),
    .b_i     (cmp_b),
    .x_i     (cmp_x_q),
    .done_o  (cmp_done),
    .win_o   (cmp_win)
  );

endmodule
`default_nettype wire

// File: src/lcsm_cmp.sv
// sequential exact height compare of two segments at one position
`default_nettype none
module lcsm_cmp import lcsm_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire seg_t           a_i,
  input  wire seg_t           b_i,
  input  wire logic [X_W-1:0] x_i,
  output logic                done_o,
  output logic                win_o
);

  logic              busy_q;
  logic [2:0]        step_q;
  logic [PROD_W-1:0] p_q, lhs_q, rhs_q;
  logic [NUM_W-1:0]  na_q, nb_q;
  logic [NUM_W-1:0]  op1;
  logic [X_W-1:0]    op2;
  logic [PROD_W-1:0] prod;
  logic              degen_a, degen_b;
  logic [X_W-1:0]    da, db;

  // point-like or out of span: height is the left y over one
  assign degen_a = (a_i.hi <= a_i.lo) || (x_i < a_i.lo) || (x_i > a_i.hi);
  assign degen_b = (b_i.hi <= b_i.lo) || (x_i < b_i.lo) || (x_i > b_i.hi);
  assign da      = degen_a ? X_W'(1) : a_i.hi - a_i.lo;
  assign db      = degen_b ? X_W'(1) : b_i.hi - b_i.lo;

  always_comb begin
    unique case (step_q)
      3'd0: begin op1 = NUM_W'(a_i.yl); op2 = a_i.hi - x_i; end
      3'd1: begin op1 = NUM_W'(a_i.yr); op2 = x_i - a_i.lo; end
      3'd2: begin op1 = NUM_W'(b_i.yl); op2 = b_i.hi - x_i; end
      3'd3: begin op1 = NUM_W'(b_i.yr); op2 = x_i - b_i.lo; end
      3'd4: begin op1 = na_q;           op2 = db;           end
      3'd5: begin op1 = nb_q;           op2 = da;           end
      default: begin op1 = '0;          op2 = '0;           end
    endcase
  end

  assign prod = op1 * op2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 3'd1;
      if (step_q == CMP_LAST) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= prod;
    unique case (step_q)
      3'd1: na_q <= degen_a ? NUM_W'(a_i.yl) : p_q[NUM_W-1:0];
      3'd2: if (!degen_a) na_q <= na_q + p_q[NUM_W-1:0];
      3'd3: nb_q <= degen_b ? NUM_W'(b_i.yl) : p_q[NUM_W-1:0];
      3'd4: if (!degen_b) nb_q <= nb_q + p_q[NUM_W-1:0];
      3'd5: lhs_q <= p_q;
      3'd6: rhs_q <= p_q;
      default: ;
    endcase
  end

  assign done_o = busy_q && (step_q == CMP_LAST);
  assign win_o  = (lhs_q != rhs_q) ? (lhs_q > rhs_q) : (a_i.id < b_i.id);

endmodule
`default_nettype wire

// File: src/lcsm_node_store.sv
// tree node memory holding best ids, with a zeroing sweep after reset
`default_nettype none
module lcsm_node_store import lcsm_pkg::*; #(
  parameter int unsigned AW = 17
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            rd_en_i,
  input  wire logic [AW-1:0]   rd_addr_i,
  input  wire logic            wr_en_i,
  input  wire logic [AW-1:0]   wr_addr_i,
  input  wire logic [ID_W-1:0] wr_data_i,
  output logic      [ID_W-1:0] rd_data_o,
  output logic                 busy_o
);

  logic [ID_W-1:0] mem [2**AW];
  logic [AW:0]     clr_q;

  assign busy_o = !clr_q[AW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (busy_o) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_o) begin
      mem[clr_q[AW-1:0]] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) rd_data_o <= mem[rd_addr_i];
  end

endmodule
`default_nettype wire

// File: src/lcsm_seg_store.sv
// segment endpoint memory indexed by id
`default_nettype none
module lcsm_seg_store #(
  parameter int unsigned AW = 16,
  parameter int unsigned DW = 92
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [DW-1:0] wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output logic      [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    if (rd_en_i) rd_data_o <= mem[rd_addr_i];
  end

endmodule
`default_nettype wire
